### design/spsp_pkg.sv
// Shared types and constants for the subpicture program stream packetizer.
package spsp_pkg;

  // Count fields are sized for the largest pack size supported (8192 bytes).
  localparam int CNT_W = 14;
  localparam int REP_W = 12;
  localparam logic [REP_W-1:0] REP_MAX = 12'hfff;

  localparam int JOB_DEPTH = 4;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  // Input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // Stream bytes
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] START_CODE_01 = 8'h01;
  localparam logic [7:0] PACK_START    = 8'hba;
  localparam logic [7:0] PACK_MUX      = 8'h40;
  localparam logic [7:0] PRIV_STREAM_1 = 8'hbd;
  localparam logic [7:0] PAD_STREAM    = 8'hbe;
  localparam logic [7:0] SUBSTREAM_ID  = 8'h20;
  localparam logic [3:0] PTS_PREFIX    = 4'h2;
  localparam logic [7:0] PES_MARK      = 8'h80;

  // Smallest padding that gets its own padding-stream packet
  localparam logic [CNT_W-1:0] PAD_PKT_MIN = 14'd6;

  // One queued unit of work: an optional payload byte, an optional pack
  // close and an optional pack open.
  typedef struct packed {
    logic             has_data;
    logic [7:0]       data_byte;
    logic             close;
    logic             pad_ge6;
    logic [CNT_W-1:0] rest;
    logic             open;
    logic             first;
    logic [32:0]      stamp;
    logic [2:0]       stuff;
    logic [CNT_W-1:0] plen;
  } job_t;

  // One stream byte, repeated cnt times
  typedef struct packed {
    logic [7:0]       value;
    logic [REP_W-1:0] cnt;
    logic             pe;
    logic             jend;
  } tok_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DATA,
    ST_PAD_ZERO2,
    ST_PAD_01,
    ST_PAD_BE,
    ST_PAD_HI,
    ST_PAD_LO,
    ST_PAD_RUN,
    ST_HDR_ZERO2,
    ST_HDR_01,
    ST_HDR_BA,
    ST_HDR_40,
    ST_HDR_ZERO11,
    ST_PES_01,
    ST_PES_BD,
    ST_PES_LEN_HI,
    ST_PES_LEN_LO,
    ST_PES_80,
    ST_PES_FLAGS,
    ST_PES_HDRLEN,
    ST_PTS0,
    ST_PTS1,
    ST_PTS2,
    ST_PTS3,
    ST_PTS4,
    ST_STUFF,
    ST_SUBID
  } step_t;

endpackage

### design/spsp_if.sv
// Channel interfaces for the packetizer input and result streams.
interface spsp_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [32:0] pts;
  logic [15:0] size;
  logic [7:0]  data_byte;

  modport source (output valid, cmd, pts, size, data_byte, input ready);
  modport sink   (input valid, cmd, pts, size, data_byte, output ready);
endinterface

interface spsp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [11:0] repeat_res;
  logic        packet_end;
  logic        last;

  modport source (output valid, out_byte, repeat_res, packet_end, last, input ready);
  modport sink   (input valid, out_byte, repeat_res, packet_end, last, output ready);
endinterface

### design/subpicture_program_stream_packetizer_top.sv
// Top level of the subpicture program stream packetizer.
//
// Wraps one subpicture into packs of PACK_BYTES bytes: a start transfer
// (cmd 0) gives the PTS and payload size and opens the first pack, each
// data transfer (cmd 1) adds one payload byte, and the byte that fills a
// pack closes it (stuffing or a padding-stream packet) and opens the next
// one while payload remains. Results come out as (byte, repeat count),
// zero runs folded into one result of up to 4095 repeats; packet_end marks
// the result that completes a pack and last the final result of a
// transfer. Stray data bytes and zero-size starts give no results. The
// front end takes one transfer per cycle into a four-entry work queue; the
// sequencer behind it issues one byte run per cycle while the merger takes
// it. A payload byte is one run; opening a pack issues the pack and PES
// headers (PTS on the first pack, stuffing when present, substream id) and
// closing with padding issues the padding-stream header and a run per up
// to 4095 padding zeros. The input stalls only while the work queue is
// full; the result register has a stage of its own, so an item is taken
// while a finished result waits. No clearing pass is needed after reset.
module subpicture_program_stream_packetizer_top import spsp_pkg::*; #(
  parameter int PACK_BYTES = 2048
) (
  input  logic       clk,
  input  logic       rst_n,
  spsp_in_if.sink    in_ch,
  spsp_out_if.source out_ch
);

  logic job_push, job_can_push, job_pop, job_valid;
  job_t job_wr, job_rd;
  logic tok_valid, tok_ready;
  tok_t tok;

  // Classify transfers and queue the work they cause
  spsp_front #(
    .PACK_BYTES (PACK_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job_ready (job_can_push),
    .job_push  (job_push),
    .job       (job_wr)
  );

  // Decouple the front end from the byte sequencer
  spsp_job_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_job  (job_wr),
    .can_push  (job_can_push),
    .pop       (job_pop),
    .pop_valid (job_valid),
    .pop_job   (job_rd)
  );

  // Expand each work item into byte runs
  spsp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_in    (job_rd),
    .job_pop   (job_pop),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_ready (tok_ready)
  );

  // Fold zero runs and hold results for the sink
  spsp_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_ready (tok_ready),
    .out_ch    (out_ch)
  );

  // A token never carries an empty run
  a_tok_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    tok_valid |-> tok.cnt != '0)
    else $error("sequencer issued an empty run");

  // Only zero bytes are ever repeated
  a_rep_zero_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.repeat_res != 12'd1) |-> out_ch.out_byte == BYTE_ZERO)
    else $error("nonzero byte carries a repeat count");

  // A result never has a zero repeat count
  a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.repeat_res != 12'd0)
    else $error("result with zero repeat count");

  // A queued work item is picked up only when the queue holds one
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_valid)
    else $error("sequencer popped an empty queue");

endmodule

### design/spsp_front.sv
// Front end: accepts items, tracks pack state and queues work descriptors.
module spsp_front import spsp_pkg::*; #(
  parameter int PACK_BYTES = 2048
) (
  input  logic       clk,
  input  logic       rst_n,
  spsp_in_if.sink    in_ch,
  input  logic       job_ready,
  output logic       job_push,
  output job_t       job
);

  localparam logic [CNT_W-1:0] CAP_FIRST = CNT_W'(PACK_BYTES - 29);
  localparam logic [CNT_W-1:0] CAP_NEXT  = CNT_W'(PACK_BYTES - 24);
  localparam logic [CNT_W-1:0] PES_BASE  = CNT_W'(4);
  localparam logic [CNT_W-1:0] PTS_LEN   = CNT_W'(5);

  logic [15:0]      br_r, br_nxt;
  logic [32:0]      stamp_r, stamp_nxt;
  logic             first_r, first_nxt;
  logic [CNT_W-1:0] pl_r, pl_nxt;
  logic [CNT_W-1:0] pad_r, pad_nxt;

  logic             acc;
  logic [15:0]      br_dec;
  logic [15:0]      calc_rem;
  logic             calc_first;
  logic [CNT_W-1:0] cap;
  logic             fits;
  logic [CNT_W-1:0] dl;
  logic [CNT_W-1:0] pad;
  logic [2:0]       stuff;
  logic [CNT_W-1:0] plen;

  assign in_ch.ready = job_ready;
  assign acc         = in_ch.valid && job_ready;
  assign br_dec      = br_r - 16'd1;

  // Pack sizing for the pack about to open
  always_comb begin
    calc_first = (in_ch.cmd == CMD_START);
    calc_rem   = calc_first ? in_ch.size : br_dec;
    cap        = calc_first ? CAP_FIRST : CAP_NEXT;
    fits       = calc_rem <= 16'(cap);
    dl         = fits ? calc_rem[CNT_W-1:0] : cap;
    pad        = fits ? (cap - calc_rem[CNT_W-1:0]) : '0;
    stuff      = (pad < PAD_PKT_MIN) ? pad[2:0] : 3'd0;
    plen       = PES_BASE + (calc_first ? PTS_LEN : '0) + dl + CNT_W'(stuff);
  end

  always_comb begin
    br_nxt    = br_r;
    stamp_nxt = stamp_r;
    first_nxt = first_r;
    pl_nxt    = pl_r;
    pad_nxt   = pad_r;
    job_push  = 1'b0;
    job       = '0;
    job.stamp = stamp_r;
    job.first = calc_first;
    job.stuff = stuff;
    job.plen  = plen;
    job.data_byte = in_ch.data_byte;
    job.pad_ge6   = pad_r >= PAD_PKT_MIN;
    job.rest      = pad_r - PAD_PKT_MIN;
    if (acc) begin
      if (in_ch.cmd == CMD_START) begin
        stamp_nxt = in_ch.pts;
        br_nxt    = in_ch.size;
        first_nxt = 1'b1;
        pl_nxt    = '0;
        pad_nxt   = '0;
        if (in_ch.size != 16'd0) begin
          job_push  = 1'b1;
          job.open  = 1'b1;
          job.stamp = in_ch.pts;
          pl_nxt    = dl;
          pad_nxt   = pad;
        end
      end else if (br_r != 16'd0 && pl_r != '0) begin
        job_push     = 1'b1;
        job.has_data = 1'b1;
        br_nxt       = br_dec;
        pl_nxt       = pl_r - CNT_W'(1);
        if (pl_r == CNT_W'(1)) begin
          job.close = 1'b1;
          first_nxt = 1'b0;
          pad_nxt   = '0;
          if (br_dec != 16'd0) begin
            job.open = 1'b1;
            pl_nxt   = dl;
            pad_nxt  = pad;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      br_r    <= '0;
      stamp_r <= '0;
      first_r <= 1'b1;
      pl_r    <= '0;
      pad_r   <= '0;
    end else begin
      br_r    <= br_nxt;
      stamp_r <= stamp_nxt;
      first_r <= first_nxt;
      pl_r    <= pl_nxt;
      pad_r   <= pad_nxt;
    end
  end

endmodule

### design/spsp_job_fifo.sv
// Short queue of work descriptors between front end and sequencer.
module spsp_job_fifo import spsp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic can_push,
  input  logic pop,
  output logic pop_valid,
  output job_t pop_job
);

  job_t                 mem_r [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [JOB_CNT_W-1:0] count_r;
  logic                 do_push, do_pop;

  assign can_push  = count_r != JOB_CNT_W'(JOB_DEPTH);
  assign pop_valid = count_r != '0;
  assign pop_job   = mem_r[rd_ptr_r];
  assign do_push   = push && can_push;
  assign do_pop    = pop && pop_valid;

  function automatic logic [JOB_PTR_W-1:0] bump(input logic [JOB_PTR_W-1:0] p);
    return (p == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : p + JOB_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= bump(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (do_push && !do_pop) begin
        count_r <= count_r + JOB_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - JOB_CNT_W'(1);
      end
    end
  end

endmodule

### design/spsp_seq.sv
// Sequencer: walks one work descriptor and emits one byte-run token a cycle while the merger takes it.
module spsp_seq import spsp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  input  job_t job_in,
  output logic job_pop,
  output logic tok_valid,
  output tok_t tok,
  input  logic tok_ready
);

  step_t            step_r, step_nxt, step_follow;
  job_t             job_r, job_nxt;
  logic [CNT_W-1:0] run_left_r, run_left_nxt;

  step_t            after_close, after_hdr, after_pts;
  logic             run_big;
  logic             advance;
  logic [15:0]      rest16, plen16;

  assign after_close = job_r.open ? ST_HDR_ZERO2 : ST_IDLE;
  assign after_pts   = (job_r.stuff != 3'd0) ? ST_STUFF : ST_SUBID;
  assign after_hdr   = job_r.first ? ST_PTS0 : after_pts;
  assign run_big     = run_left_r > CNT_W'(REP_MAX);
  assign advance     = tok_ready && (step_r != ST_IDLE);
  assign rest16      = 16'(job_r.rest);
  assign plen16      = 16'(job_r.plen);

  // Next state
  always_comb begin
    step_follow = ST_IDLE;
    case (step_r)
      ST_IDLE:       step_follow = ST_IDLE;
      ST_DATA: begin
        if (!job_r.close) begin
          step_follow = ST_IDLE;
        end else begin
          step_follow = job_r.pad_ge6 ? ST_PAD_ZERO2 : after_close;
        end
      end
      ST_PAD_ZERO2:  step_follow = ST_PAD_01;
      ST_PAD_01:     step_follow = ST_PAD_BE;
      ST_PAD_BE:     step_follow = ST_PAD_HI;
      ST_PAD_HI:     step_follow = ST_PAD_LO;
      ST_PAD_LO:     step_follow = (job_r.rest != '0) ? ST_PAD_RUN : after_close;
      ST_PAD_RUN:    step_follow = run_big ? ST_PAD_RUN : after_close;
      ST_HDR_ZERO2:  step_follow = ST_HDR_01;
      ST_HDR_01:     step_follow = ST_HDR_BA;
      ST_HDR_BA:     step_follow = ST_HDR_40;
      ST_HDR_40:     step_follow = ST_HDR_ZERO11;
      ST_HDR_ZERO11: step_follow = ST_PES_01;
      ST_PES_01:     step_follow = ST_PES_BD;
      ST_PES_BD:     step_follow = ST_PES_LEN_HI;
      ST_PES_LEN_HI: step_follow = ST_PES_LEN_LO;
      ST_PES_LEN_LO: step_follow = ST_PES_80;
      ST_PES_80:     step_follow = ST_PES_FLAGS;
      ST_PES_FLAGS:  step_follow = ST_PES_HDRLEN;
      ST_PES_HDRLEN: step_follow = after_hdr;
      ST_PTS0:       step_follow = ST_PTS1;
      ST_PTS1:       step_follow = ST_PTS2;
      ST_PTS2:       step_follow = ST_PTS3;
      ST_PTS3:       step_follow = ST_PTS4;
      ST_PTS4:       step_follow = after_pts;
      ST_STUFF:      step_follow = ST_SUBID;
      ST_SUBID:      step_follow = ST_IDLE;
      default:       step_follow = ST_IDLE;
    endcase

    // Load the next descriptor as soon as the current one issues its last token
    job_pop = job_valid && ((step_r == ST_IDLE) || (advance && step_follow == ST_IDLE));

    step_nxt     = step_r;
    job_nxt      = job_r;
    run_left_nxt = run_left_r;
    if (job_pop) begin
      step_nxt     = job_in.has_data ? ST_DATA : ST_HDR_ZERO2;
      job_nxt      = job_in;
      run_left_nxt = job_in.rest;
    end else if (advance) begin
      step_nxt = step_follow;
      if (step_r == ST_PAD_RUN && run_big) begin
        run_left_nxt = run_left_r - CNT_W'(REP_MAX);
      end
    end
  end

  // Outputs
  always_comb begin
    tok_valid = step_r != ST_IDLE;
    tok.value = BYTE_ZERO;
    tok.cnt   = REP_W'(1);
    tok.pe    = 1'b0;
    tok.jend  = step_follow == ST_IDLE;
    case (step_r)
      ST_IDLE:       tok.value = BYTE_ZERO;
      ST_DATA: begin
        tok.value = job_r.data_byte;
        tok.pe    = job_r.close && !job_r.pad_ge6;
      end
      ST_PAD_ZERO2:  tok.cnt   = REP_W'(2);
      ST_PAD_01:     tok.value = START_CODE_01;
      ST_PAD_BE:     tok.value = PAD_STREAM;
      ST_PAD_HI:     tok.value = rest16[15:8];
      ST_PAD_LO: begin
        tok.value = rest16[7:0];
        tok.pe    = job_r.rest == '0;
      end
      ST_PAD_RUN: begin
        tok.cnt = run_big ? REP_MAX : run_left_r[REP_W-1:0];
        tok.pe  = !run_big;
      end
      ST_HDR_ZERO2:  tok.cnt   = REP_W'(2);
      ST_HDR_01:     tok.value = START_CODE_01;
      ST_HDR_BA:     tok.value = PACK_START;
      ST_HDR_40:     tok.value = PACK_MUX;
      ST_HDR_ZERO11: tok.cnt   = REP_W'(11);
      ST_PES_01:     tok.value = START_CODE_01;
      ST_PES_BD:     tok.value = PRIV_STREAM_1;
      ST_PES_LEN_HI: tok.value = plen16[15:8];
      ST_PES_LEN_LO: tok.value = plen16[7:0];
      ST_PES_80:     tok.value = PES_MARK;
      ST_PES_FLAGS:  tok.value = job_r.first ? PES_MARK : BYTE_ZERO;
      ST_PES_HDRLEN: tok.value = (job_r.first ? 8'd5 : 8'd0) + 8'(job_r.stuff);
      ST_PTS0:       tok.value = {PTS_PREFIX, job_r.stamp[32:30], 1'b1};
      ST_PTS1:       tok.value = job_r.stamp[29:22];
      ST_PTS2:       tok.value = {job_r.stamp[21:15], 1'b1};
      ST_PTS3:       tok.value = job_r.stamp[14:7];
      ST_PTS4:       tok.value = {job_r.stamp[6:0], 1'b1};
      ST_STUFF:      tok.cnt   = REP_W'(job_r.stuff);
      ST_SUBID:      tok.value = SUBSTREAM_ID;
      default:       tok.value = BYTE_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    run_left_r <= run_left_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

### design/spsp_merge.sv
// Run merger: folds zero runs into repeat counts and drives the result register.
module spsp_merge import spsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      tok_valid,
  input  tok_t      tok,
  output logic      tok_ready,
  spsp_out_if.source out_ch
);

  logic             p_valid_r, p_valid_nxt;
  logic [7:0]       p_value_r, p_value_nxt;
  logic [REP_W-1:0] p_rep_r, p_rep_nxt;
  logic             p_pe_r, p_pe_nxt;
  logic             p_fin_r, p_fin_nxt;

  logic             o_valid_r;
  logic [7:0]       o_value_r;
  logic [REP_W-1:0] o_rep_r;
  logic             o_pe_r, o_last_r;

  logic             o_free, can_merge, split, adv, emit;
  logic [REP_W:0]   sum;
  logic [7:0]       e_value;
  logic [REP_W-1:0] e_rep;
  logic             e_pe, e_last;

  assign o_free = !o_valid_r || out_ch.ready;
  assign sum    = {1'b0, p_rep_r} + {1'b0, tok.cnt};
  assign split  = sum > {1'b0, REP_MAX};
  // Merge only zero into an open zero run of the same input, not past a pack end
  assign can_merge = tok_valid && p_valid_r && !p_fin_r && !p_pe_r &&
                     p_value_r == BYTE_ZERO && tok.value == BYTE_ZERO;

  always_comb begin
    adv         = 1'b0;
    emit        = 1'b0;
    e_value     = p_value_r;
    e_rep       = p_rep_r;
    e_pe        = p_pe_r;
    e_last      = p_fin_r;
    p_valid_nxt = p_valid_r;
    p_value_nxt = p_value_r;
    p_rep_nxt   = p_rep_r;
    p_pe_nxt    = p_pe_r;
    p_fin_nxt   = p_fin_r;
    if (tok_valid) begin
      if (can_merge && !split) begin
        adv = 1'b1;
        p_rep_nxt = sum[REP_W-1:0];
        p_pe_nxt  = tok.pe;
        p_fin_nxt = tok.jend;
      end else if (can_merge) begin
        // Fill the held run to the limit and carry the rest
        emit    = 1'b1;
        e_value = BYTE_ZERO;
        e_rep   = REP_MAX;
        e_pe    = 1'b0;
        e_last  = 1'b0;
        adv     = o_free;
        if (adv) begin
          p_rep_nxt = REP_W'(sum - {1'b0, REP_MAX});
          p_pe_nxt  = tok.pe;
          p_fin_nxt = tok.jend;
        end
      end else begin
        emit = p_valid_r;
        adv  = !p_valid_r || o_free;
        if (adv) begin
          p_valid_nxt = 1'b1;
          p_value_nxt = tok.value;
          p_rep_nxt   = tok.cnt;
          p_pe_nxt    = tok.pe;
          p_fin_nxt   = tok.jend;
        end
      end
    end else if (p_valid_r && p_fin_r) begin
      emit = 1'b1;
      adv  = o_free;
      if (adv) begin
        p_valid_nxt = 1'b0;
      end
    end
  end

  assign tok_ready         = tok_valid && adv;
  assign out_ch.valid      = o_valid_r;
  assign out_ch.out_byte   = o_value_r;
  assign out_ch.repeat_res = o_rep_r;
  assign out_ch.packet_end = o_pe_r;
  assign out_ch.last       = o_last_r;

  always_ff @(posedge clk) begin
    p_value_r <= p_value_nxt;
    p_rep_r   <= p_rep_nxt;
    p_pe_r    <= p_pe_nxt;
    p_fin_r   <= p_fin_nxt;
    if (adv && emit) begin
      o_value_r <= e_value;
      o_rep_r   <= e_rep;
      o_pe_r    <= e_pe;
      o_last_r  <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      p_valid_r <= p_valid_nxt;
      if (adv && emit) begin
        o_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

endmodule

### sim/spsp_stream_checker.sv
// Stream checker: predicts packetizer results from input transfers and compares them.
module spsp_stream_checker import spsp_pkg::*; #(
  parameter int PACK_BYTES = 2048
) (
  input  logic clk,
  input  logic rst_n,
  spsp_in_if   in_mon,
  spsp_out_if  out_mon,
  output int   fail_count,
  output int   runs_pending
);

  localparam int          PACK_OVERHEAD = 24;
  localparam int          PTS_BYTES     = 5;
  localparam int          MAX_RUNS      = 31;
  localparam logic [7:0]  PTS_FLAG      = 8'h80;

  typedef struct packed {
    logic [7:0]       value;
    logic [REP_W-1:0] reps;
    logic             pack_end;
    logic             item_last;
  } stream_run_t;

  stream_run_t runs_due[$];
  stream_run_t step_runs[$];

  logic [15:0] left_total;
  logic [32:0] cur_pts;
  logic        on_first;
  int unsigned pack_payload_left;
  int unsigned pack_pad;

  int mismatches = 0;
  int due_count  = 0;
  int run_index  = 0;

  assign fail_count   = mismatches;
  assign runs_pending = due_count;

  task automatic report_mismatch(input string what);
    $display("spsp check: result %0d: %s", run_index, what);
    mismatches++;
  endtask

  // Append one stream byte; zeros fold into an open zero run.
  task automatic put_run(input logic [7:0] b);
    stream_run_t r;
    int          idx;
    idx = step_runs.size() - 1;
    if (b == BYTE_ZERO && idx >= 0) begin
      r = step_runs[idx];
      if (r.value == BYTE_ZERO && r.reps < REP_MAX && !r.pack_end) begin
        r.reps = r.reps + 1'b1;
        step_runs[idx] = r;
        return;
      end
    end
    if (step_runs.size() >= MAX_RUNS) return;
    r = '{value: b, reps: 12'd1, pack_end: 1'b0, item_last: 1'b0};
    step_runs.push_back(r);
  endtask

  task automatic put_zero_run(input int unsigned n);
    repeat (n) put_run(BYTE_ZERO);
  endtask

  task automatic open_pack();
    int unsigned pts_len;
    int unsigned cap;
    int unsigned dl;
    int unsigned pad;
    int unsigned stuff;
    logic [15:0] pes_len;
    pts_len = on_first ? PTS_BYTES : 0;
    cap     = PACK_BYTES - PACK_OVERHEAD - pts_len;
    if (left_total <= cap) begin
      pad = cap - left_total;
      dl  = left_total;
    end else begin
      pad = 0;
      dl  = cap;
    end
    stuff   = (pad < PAD_PKT_MIN) ? pad : 0;
    pes_len = 16'(3 + pts_len + 1 + dl + stuff);

    put_run(BYTE_ZERO); put_run(BYTE_ZERO); put_run(START_CODE_01);
    put_run(PACK_START); put_run(PACK_MUX);
    put_zero_run(9);
    put_run(BYTE_ZERO); put_run(BYTE_ZERO); put_run(START_CODE_01); put_run(PRIV_STREAM_1);
    put_run(pes_len[15:8]);
    put_run(pes_len[7:0]);
    put_run(PES_MARK);
    put_run(on_first ? PTS_FLAG : BYTE_ZERO);
    put_run(8'(pts_len + stuff));
    if (on_first) begin
      put_run({PTS_PREFIX, cur_pts[32:30], 1'b1});
      put_run(cur_pts[29:22]);
      put_run({cur_pts[21:15], 1'b1});
      put_run(cur_pts[14:7]);
      put_run({cur_pts[6:0], 1'b1});
    end
    put_zero_run(stuff);
    put_run(SUBSTREAM_ID);

    pack_payload_left = dl;
    pack_pad          = pad;
  endtask

  task automatic close_pack();
    logic [15:0] pad_rest;
    stream_run_t r;
    if (pack_pad >= PAD_PKT_MIN) begin
      pad_rest = 16'(pack_pad - PAD_PKT_MIN);
      put_run(BYTE_ZERO); put_run(BYTE_ZERO); put_run(START_CODE_01); put_run(PAD_STREAM);
      put_run(pad_rest[15:8]);
      put_run(pad_rest[7:0]);
      put_zero_run(pad_rest);
    end
    if (step_runs.size() > 0) begin
      r = step_runs[step_runs.size() - 1];
      r.pack_end = 1'b1;
      step_runs[step_runs.size() - 1] = r;
    end
    on_first = 1'b0;
    pack_pad = 0;
  endtask

  task automatic predict_transfer(input logic cmd, input logic [32:0] pts,
                                  input logic [15:0] size, input logic [7:0] data);
    stream_run_t r;
    step_runs.delete();
    if (cmd == CMD_START) begin
      cur_pts           = pts;
      left_total        = size;
      on_first          = 1'b1;
      pack_payload_left = 0;
      pack_pad          = 0;
      if (left_total != 0) open_pack();
    end else if (left_total != 0 && pack_payload_left != 0) begin
      put_run(data);
      left_total        = left_total - 16'd1;
      pack_payload_left = pack_payload_left - 1;
      if (pack_payload_left == 0) begin
        close_pack();
        if (left_total != 0) open_pack();
      end
    end
    if (step_runs.size() > 0) begin
      r = step_runs[step_runs.size() - 1];
      r.item_last = 1'b1;
      step_runs[step_runs.size() - 1] = r;
    end
    foreach (step_runs[i]) runs_due.push_back(step_runs[i]);
  endtask

  task automatic check_run(input logic [7:0] b, input logic [REP_W-1:0] n,
                           input logic pe, input logic lst);
    stream_run_t want;
    if (runs_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result %02h x%0d", b, n));
    end else begin
      want = runs_due.pop_front();
      if (b !== want.value)
        report_mismatch($sformatf("out_byte %02h, want %02h", b, want.value));
      if (n !== want.reps)
        report_mismatch($sformatf("repeat_res %0d, want %0d", n, want.reps));
      if (pe !== want.pack_end)
        report_mismatch($sformatf("packet_end %b, want %b", pe, want.pack_end));
      if (lst !== want.item_last)
        report_mismatch($sformatf("last %b, want %b", lst, want.item_last));
    end
    run_index++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      runs_due.delete();
      left_total        = '0;
      cur_pts           = '0;
      on_first          = 1'b1;
      pack_payload_left = 0;
      pack_pad          = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        predict_transfer(in_mon.cmd, in_mon.pts, in_mon.size, in_mon.data_byte);
      if (out_mon.valid && out_mon.ready)
        check_run(out_mon.out_byte, out_mon.repeat_res, out_mon.packet_end, out_mon.last);
    end
    due_count = runs_due.size();
  end

endmodule

### sim/subpicture_program_stream_packetizer_top_tb.sv
// Testbench top: stimulus, receiver backpressure and verdict for the packetizer.
module subpicture_program_stream_packetizer_top_tb import spsp_pkg::*; ();

  localparam int PACK_BYTES   = 2048;
  localparam int RESET_CYCLES = 10;
  // Longest legal quiet stretch is the receiver hold-off plus a padding
  // burst; allow well over that before calling it a hang.
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 30;

  logic clk = 1'b0;
  logic rst_n;

  spsp_in_if  in_ch();
  spsp_out_if out_ch();

  int          fail_count;
  int          runs_pending;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asked     = 0;
  int unsigned quiet_cycles   = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  subpicture_program_stream_packetizer_top #(.PACK_BYTES(PACK_BYTES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  spsp_stream_checker #(.PACK_BYTES(PACK_BYTES)) stream_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .runs_pending (runs_pending)
  );

  function automatic logic [32:0] rand_stamp();
    return {$urandom_range(1) == 1, $urandom};
  endfunction

  // Bias toward zero so payload zeros fold into header and padding runs.
  function automatic logic [7:0] rand_payload_byte();
    return ($urandom_range(9) < 3) ? 8'h00 : 8'($urandom);
  endfunction

  // Offer one transfer and hold it until taken. Entered and left at a
  // falling edge; a back-to-back transfer keeps valid high without a dip.
  task automatic send_item(input logic c, input logic [32:0] p, input logic [15:0] s,
                           input logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= c;
    in_ch.pts       <= p;
    in_ch.size      <= s;
    in_ch.data_byte <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Payload bytes; the unused start fields carry noise.
  task automatic send_payload(input int unsigned n);
    repeat (n) send_item(CMD_DATA, rand_stamp(), 16'($urandom), rand_payload_byte());
  endtask

  // Receiver: random stalls per phase, plus a long hold-off on request,
  // counted here so the sender keeps pushing until the work queue fills.
  initial begin : recv_ready
    int unsigned hold_started;
    int unsigned hold_left;
    hold_started = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_started != hold_asked) begin
        hold_started = hold_asked;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("subpicture_program_stream_packetizer_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned counted;
    int unsigned pick;
    int unsigned sent;
    logic [15:0] size;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_START;
    in_ch.pts       = '0;
    in_ch.size      = '0;
    in_ch.data_byte = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    // Stray byte right after reset: nothing expected.
    send_item(CMD_DATA, '0, '0, 8'hff);
    // Zero-size start opens no pack.
    send_item(CMD_START, 33'h0_0000_0000, 16'd0, 8'h00);
    // One-byte subpicture, all-ones PTS; zero payload folds into padding.
    send_item(CMD_START, 33'h1_ffff_ffff, 16'd1, 8'h00);
    send_item(CMD_DATA, '0, '0, 8'h00);
    // Stray byte once the subpicture is done.
    send_item(CMD_DATA, '0, '0, 8'ha5);
    // Largest size, abandoned by a new start a few bytes in.
    send_item(CMD_START, 33'h0_5555_5555, 16'hffff, 8'h00);
    send_item(CMD_DATA, '0, '0, 8'hff);
    send_item(CMD_DATA, '0, '0, 8'h00);
    send_item(CMD_DATA, '0, '0, 8'h5a);
    send_item(CMD_START, 33'h1_aaaa_aaaa, 16'd3, 8'hff);
    send_item(CMD_DATA, '0, '0, 8'h00);
    send_item(CMD_DATA, '0, '0, 8'h00);
    send_item(CMD_DATA, '0, '0, 8'h80);
    send_item(CMD_START, 33'h1_0000_0001, 16'd2, 8'h00);
    send_item(CMD_DATA, '0, '0, 8'h01);
    send_item(CMD_DATA, '0, '0, 8'h00);
    // Zero-size start while a pack is open abandons it; the next byte is stray.
    send_item(CMD_START, 33'h0_8000_0000, 16'd5, 8'h00);
    send_item(CMD_DATA, '0, '0, 8'h33);
    send_item(CMD_START, 33'h0_7fff_ffff, 16'd0, 8'h00);
    send_item(CMD_DATA, '0, '0, 8'h7f);

    // Random part, one phase per idling mode.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase

      if (ph == 0) begin
        // Hold off the receiver while a subpicture streams in at full rate.
        hold_asked = hold_asked + 1;
        send_item(CMD_START, rand_stamp(), 16'd40, rand_payload_byte());
        send_payload(40);
      end

      counted = 0;
      while (counted < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          // Well-formed short subpicture.
          size = 16'($urandom_range(24, 1));
          send_item(CMD_START, rand_stamp(), size, rand_payload_byte());
          send_payload(size);
          counted = counted + 1 + size;
        end else if (pick < 82) begin
          // Broken: start, then only part of the payload.
          size = ($urandom_range(1) == 1) ? 16'($urandom) : 16'($urandom_range(30, 2));
          sent = (size == 0) ? 0 : $urandom_range((size > 16'd6) ? 6 : size - 16'd1);
          send_item(CMD_START, rand_stamp(), size, rand_payload_byte());
          send_payload(sent);
          counted = counted + 1 + sent;
        end else if (pick < 90) begin
          send_item(CMD_START, rand_stamp(), 16'd0, rand_payload_byte());
          counted = counted + 1;
        end else begin
          // Noise bytes; usually stray, so not counted.
          send_payload($urandom_range(3, 1));
        end
      end
    end

    in_ch.valid <= 1'b0;

    // Drain: wait for every expected result, then let the pipe settle.
    while (runs_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("subpicture_program_stream_packetizer_top verification clean");
    end else begin
      $display("subpicture_program_stream_packetizer_top verification failed");
    end
    $finish;
  end

endmodule
